/* rtl/sidta_pkg.sv */
package sidta_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned NDIGITS = 10;
    localparam int unsigned CNT_W   = $clog2(NDIGITS);

    // q = (x * RECIP) >> RECIP_SHIFT equals x / 10 for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP       = 32'hCCCC_CCCD;
    localparam int unsigned        RECIP_SHIFT = 35;
    localparam int unsigned        QUOT_W      = 2 * VALUE_W - RECIP_SHIFT;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } t_state;

endpackage

/* rtl/signed_int_to_decimal_ascii.sv */
// signed 32-bit integer to decimal ascii text
//
// input channel: i_value with i_valid / o_ready. one transaction carries one
// two's complement integer. o_ready is high only while the block is idle.
// output channel: o_character and o_last with o_valid / i_ready. one
// transaction carries one character: '-' first for a negative value, then
// the digits most significant first, o_last high on the final digit.
// timing: after an input transaction the magnitude is divided by ten once a
// cycle on one shared 32x32 reciprocal multiplier, after a setup step that
// forms the first product, giving one digit per division (1 to 10 digits).
// characters then leave at one per cycle while the receiver takes them. the
// next input is taken in the cycle after the last character is loaded.
// a stalled receiver holds the output register and the emit sequence waits;
// no character is lost or repeated.
// reset (synchronous, active low) returns to idle and drops any pending
// output; no memory needs clearing.
module signed_int_to_decimal_ascii (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [sidta_pkg::VALUE_W-1:0] i_value,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [sidta_pkg::CHAR_W-1:0]     o_character,
    output logic                             o_last
);

    sidta_pkg::t_state r_state, n_state;
    logic                           r_neg, n_neg;
    logic [sidta_pkg::VALUE_W-1:0]  r_mag, n_mag;
    logic [2*sidta_pkg::VALUE_W-1:0] r_prod, n_prod;
    logic [sidta_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [sidta_pkg::DIGIT_W-1:0]  r_dig [sidta_pkg::NDIGITS];
    logic                           r_out_valid, n_out_valid;
    logic [sidta_pkg::CHAR_W-1:0]   r_char, n_char;
    logic                           r_last, n_last;

    logic [sidta_pkg::VALUE_W-1:0]   w_mul_a;
    logic [2*sidta_pkg::VALUE_W-1:0] w_prod;
    logic [sidta_pkg::QUOT_W-1:0]    w_quot;
    logic [sidta_pkg::VALUE_W-1:0]   w_quot10;
    logic [sidta_pkg::DIGIT_W-1:0]   w_digit;
    logic                            w_dig_we;
    logic                            w_load_ok;

    assign w_quot   = r_prod[2*sidta_pkg::VALUE_W-1:sidta_pkg::RECIP_SHIFT];
    assign w_quot10 = {w_quot, 3'b000} + {2'b00, w_quot, 1'b0};
    assign w_digit  = sidta_pkg::DIGIT_W'(r_mag - w_quot10);

    // shared divide-by-ten multiplier
    assign w_mul_a = (r_state == sidta_pkg::ST_DIV) ?
                     {{(sidta_pkg::VALUE_W-sidta_pkg::QUOT_W){1'b0}}, w_quot} : r_mag;
    assign w_prod  = {{sidta_pkg::VALUE_W{1'b0}}, w_mul_a} *
                     {{sidta_pkg::VALUE_W{1'b0}}, sidta_pkg::RECIP};

    assign w_load_ok = !r_out_valid || i_ready;

    assign o_ready     = (r_state == sidta_pkg::ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_prod      = r_prod;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_char      = r_char;
        n_last      = r_last;
        w_dig_we    = 1'b0;
        case (r_state)
            sidta_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_neg   = i_value[sidta_pkg::VALUE_W-1];
                    n_mag   = i_value[sidta_pkg::VALUE_W-1] ?
                              (~i_value + 1'b1) : i_value;
                    n_cnt   = '0;
                    n_state = sidta_pkg::ST_PREP;
                end
            end
            sidta_pkg::ST_PREP: begin
                n_prod  = w_prod;
                n_state = sidta_pkg::ST_DIV;
            end
            sidta_pkg::ST_DIV: begin
                w_dig_we = 1'b1;
                n_mag    = {{(sidta_pkg::VALUE_W-sidta_pkg::QUOT_W){1'b0}}, w_quot};
                n_prod   = w_prod;
                if (w_quot == '0) begin
                    n_state = r_neg ? sidta_pkg::ST_SIGN : sidta_pkg::ST_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            sidta_pkg::ST_SIGN: begin
                if (w_load_ok) begin
                    n_out_valid = 1'b1;
                    n_char      = sidta_pkg::CHAR_MINUS;
                    n_last      = 1'b0;
                    n_state     = sidta_pkg::ST_EMIT;
                end
            end
            sidta_pkg::ST_EMIT: begin
                if (w_load_ok) begin
                    n_out_valid = 1'b1;
                    n_char      = sidta_pkg::CHAR_ZERO +
                                  {{(sidta_pkg::CHAR_W-sidta_pkg::DIGIT_W){1'b0}}, r_dig[r_cnt]};
                    n_last      = (r_cnt == '0);
                    if (r_cnt == '0) begin
                        n_state = sidta_pkg::ST_IDLE;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            default: begin
                n_state = sidta_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sidta_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_prod <= n_prod;
        r_cnt  <= n_cnt;
        r_char <= n_char;
        r_last <= n_last;
    end

    // digit buffer, least significant digit at index zero
    always_ff @(posedge i_clk) begin
        if (w_dig_we) begin
            r_dig[r_cnt] <= w_digit;
        end
    end

endmodule
